[hdl/merge_sorter_macros.svh]
// Assertion macros for the merge sorter.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef MERGE_SORTER_MACROS_SVH
`define MERGE_SORTER_MACROS_SVH
`ifndef SYNTHESIS
`define MS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MS_ASSERT_IMP(lbl, ante, cons, msg)
`define MS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/ms_pkg.sv]
// Shared types and constants for the merge sorter.
// No dependencies; used by ms_ram and merge_sorter.
`timescale 1ns / 1ps

package ms_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

endpackage

[hdl/ms_ram.sv]
// Generic RAM: one write port, two read ports, registered read data.
// Default width from ms_pkg::DATA_W.
`timescale 1ns / 1ps

module ms_ram #(
  parameter int WIDTH = ms_pkg::DATA_W,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

[hdl/merge_sorter.sv]
// Merge sorter top level: load, bottom-up merge passes, emit.
// Depends on ms_pkg, ms_ram and merge_sorter_macros.svh.
`timescale 1ns / 1ps
`include "merge_sorter_macros.svh"

// Usage:
//  in_*  : one signed 32-bit value per transfer in in_tdata; in_tlast closes the set.
//          in_tready is high only while the block is collecting a set.
//  out_* : the set in ascending order, stable on equal values; out_tlast on the
//          final element, out_tuser high on every element of a set that lost
//          values because the store (CAPACITY entries) was full.
// Steps for a set of n stored values:
//  load    one transfer per cycle
//  sort    ceil(log2 n) passes, each a PRIME setup state, then one
//          compare-and-write per element through the shared comparator
//  emit    an EPRIME setup state, then one element per cycle while out_tready is high
//  The comparator and the two-read-port memories set the pass length.
//  The next set can load while the final result still waits in the output register.
// Reset: rst_n synchronous, active low; clears the state, the element count, the overflow
//  flag and the output valid. The memories are not cleared; only entries
//  written in the current set are ever read.
// Stall: a held out_tready freezes the emit sequencer; no result is lost.
module merge_sorter #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] sorted_value
  output logic        out_tlast,
  output logic        out_tuser    // [0] dropped
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [2:0] {LOAD, PRIME, MERGE, EPRIME, EMIT} state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic ovf_r, ovf_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] w_r, w_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [CW-1:0] mid_r, mid_nxt, hi_r, hi_nxt;
  logic src_b_r, src_b_nxt;
  logic out_valid_r, out_valid_nxt;
  ms_pkg::data_t out_data_r, out_data_nxt;
  logic out_last_r, out_last_nxt;
  logic out_drop_r, out_drop_nxt;

  logic in_xfer;
  logic a_we, b_we;
  logic [AW-1:0] a_waddr;
  ms_pkg::data_t a_wdata;
  ms_pkg::data_t a_rd0, a_rd1, b_rd0, b_rd1;
  ms_pkg::data_t src_i, src_j, merge_d;
  logic take_left;
  logic [CW-1:0] k_inc, i_inc;
  logic run_end;
  logic [CW:0] w2;
  logic [CW-1:0] p_mid, p_hi, r_mid, r_hi;

  function automatic logic [CW-1:0] clip_n(input logic [CW:0] x, input logic [CW-1:0] lim);
    if (x > {1'b0, lim}) begin
      clip_n = lim;
    end else begin
      clip_n = x[CW-1:0];
    end
  endfunction

  assign in_tready  = (state_r == LOAD);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_drop_r;

  // shared comparator: left run wins on ties
  assign src_i     = src_b_r ? b_rd0 : a_rd0;
  assign src_j     = src_b_r ? b_rd1 : a_rd1;
  assign take_left = (i_r < mid_r) && ((j_r >= hi_r) || (src_i <= src_j));
  assign merge_d   = take_left ? src_i : src_j;
  assign k_inc     = k_r + CW'(1);
  assign i_inc     = i_r + CW'(1);
  assign run_end   = (k_inc == hi_r);

  // bounds of the first run pair of the next pass, and of the next pair in this pass
  assign w2    = {1'b0, w_r} << 1;
  assign p_mid = clip_n(w2, n_r);
  assign p_hi  = clip_n({1'b0, p_mid} + w2, n_r);
  assign r_mid = clip_n({1'b0, hi_r} + {1'b0, w_r}, n_r);
  assign r_hi  = clip_n({1'b0, r_mid} + {1'b0, w_r}, n_r);

  assign a_we    = (in_xfer && (count_r < CAP_C)) || ((state_r == MERGE) && src_b_r);
  assign b_we    = (state_r == MERGE) && !src_b_r;
  assign a_waddr = (state_r == LOAD) ? count_r[AW-1:0] : k_r[AW-1:0];
  assign a_wdata = (state_r == LOAD) ? ms_pkg::data_t'(in_tdata) : merge_d;

  ms_ram #(.WIDTH(ms_pkg::DATA_W), .DEPTH(CAPACITY)) u_store (
    .clk    (clk),
    .we     (a_we),
    .waddr  (a_waddr),
    .wdata  (a_wdata),
    .raddr0 (i_nxt[AW-1:0]),
    .raddr1 (j_nxt[AW-1:0]),
    .rdata0 (a_rd0),
    .rdata1 (a_rd1)
  );

  ms_ram #(.WIDTH(ms_pkg::DATA_W), .DEPTH(CAPACITY)) u_scratch (
    .clk    (clk),
    .we     (b_we),
    .waddr  (k_r[AW-1:0]),
    .wdata  (merge_d),
    .raddr0 (i_nxt[AW-1:0]),
    .raddr1 (j_nxt[AW-1:0]),
    .rdata0 (b_rd0),
    .rdata1 (b_rd1)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    n_nxt         = n_r;
    w_nxt         = w_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    src_b_nxt     = src_b_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_drop_nxt  = out_drop_r;

    case (state_r)
      LOAD: begin
        if (in_xfer) begin
          if (count_r < CAP_C) begin
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            n_nxt     = count_nxt;
            src_b_nxt = 1'b0;
            i_nxt     = '0;
            k_nxt     = '0;
            w_nxt     = CW'(1);
            mid_nxt   = CW'(1);
            hi_nxt    = CW'(2);
            j_nxt     = CW'(1);
            state_nxt = (count_nxt == CW'(1)) ? EPRIME : PRIME;
          end
        end
      end
      PRIME: begin
        state_nxt = MERGE;
      end
      MERGE: begin
        if (run_end) begin
          if (hi_r == n_r) begin
            src_b_nxt = !src_b_r;
            i_nxt     = '0;
            k_nxt     = '0;
            if (w2 >= {1'b0, n_r}) begin
              state_nxt = EPRIME;
            end else begin
              w_nxt     = w2[CW-1:0];
              mid_nxt   = p_mid;
              hi_nxt    = p_hi;
              j_nxt     = p_mid;
              state_nxt = PRIME;
            end
          end else begin
            i_nxt   = hi_r;
            k_nxt   = k_inc;
            mid_nxt = r_mid;
            hi_nxt  = r_hi;
            j_nxt   = r_mid;
          end
        end else begin
          k_nxt = k_inc;
          if (take_left) begin
            i_nxt = i_inc;
          end else begin
            j_nxt = j_r + CW'(1);
          end
        end
      end
      EPRIME: begin
        i_nxt     = '0;
        state_nxt = EMIT;
      end
      EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = src_i;
          out_last_nxt  = (i_inc == n_r);
          out_drop_nxt  = ovf_r;
          if (i_inc == n_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = LOAD;
          end else begin
            i_nxt = i_inc;
          end
        end
      end
      default: begin
        state_nxt = LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    w_r        <= w_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    mid_r      <= mid_nxt;
    hi_r       <= hi_nxt;
    src_b_r    <= src_b_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_drop_r <= out_drop_nxt;
  end

  `MS_ASSERT_IMP(a_merge_bounds, state_r == MERGE, (k_r < hi_r) && (i_r <= mid_r) && (j_r <= hi_r) && (hi_r <= n_r), "merge indexes outside the current run pair")
  `MS_ASSERT_NXT(a_full_sets_ovf, in_xfer && (count_r == CAP_C), ovf_r, "transfer into a full store did not set the overflow flag")
  `MS_ASSERT_IMP(a_emit_count, state_r == EMIT, (n_r != '0) && (i_r < n_r), "emit index outside the stored set")

endmodule
